// ===== rtl/trpn_pkg.sv =====
// ----------------------------------------------------------------------------
// trpn_pkg: shared types and constants of the typed RPN stack ALU
// Command codes, status codes and the element type held by each stack cell.
// ----------------------------------------------------------------------------
package trpn_pkg;

  localparam int KindW   = 5;
  localparam int DataW   = 32;
  localparam int StatusW = 3;
  localparam int DepthOW = 7;

  typedef enum logic [KindW-1:0] {
    K_PUSH_INT  = 5'd0,
    K_PUSH_BOOL = 5'd1,
    K_NOT       = 5'd2,
    K_CLEAR     = 5'd3,
    K_DROP      = 5'd4,
    K_DUP       = 5'd5,
    K_SWAP      = 5'd6,
    K_PRINT     = 5'd7,
    K_ADD       = 5'd8,
    K_SUB       = 5'd9,
    K_MUL       = 5'd10,
    K_DIV       = 5'd11,
    K_MOD       = 5'd12,
    K_LT        = 5'd13,
    K_GT        = 5'd14,
    K_LE        = 5'd15,
    K_GE        = 5'd16,
    K_EQ        = 5'd17
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_TYPE  = 3'd2,
    ST_DIV0  = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  // Shift command applied to every cell but the top one in the same cycle.
  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_PUSH = 2'd1,
    SH_POP  = 2'd2
  } shift_e;

  typedef struct packed {
    logic             tag;
    logic [DataW-1:0] value;
  } elem_t;

  typedef struct packed {
    shift_e shift;
    logic   load_top;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_R,
    S_POP_L,
    S_DIV,
    S_PUSH2,
    S_PUSH,
    S_DONE
  } state_e;

endpackage

// ===== rtl/trpn_if.sv =====
// ----------------------------------------------------------------------------
// trpn_if: valid/ready channel
// Carries one item with its payload from a source to a sink.
// ----------------------------------------------------------------------------
interface trpn_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [trpn_pkg::KindW-1:0] kind;
  logic signed [31:0]         operand_value;
  modport source (output valid, kind, operand_value, input ready);
  modport sink (input valid, kind, operand_value, output ready);
endinterface

interface trpn_res_if;
  logic                         valid;
  logic                         ready;
  logic [trpn_pkg::StatusW-1:0] status;
  logic                         print_valid;
  logic signed [31:0]           print_value;
  logic                         print_is_bool;
  logic [trpn_pkg::DepthOW-1:0] stack_depth;
  modport source (output valid, status, print_valid, print_value, print_is_bool,
                  stack_depth, input ready);
  modport sink (input valid, status, print_valid, print_value, print_is_bool,
                stack_depth, output ready);
endinterface

// ===== rtl/trpn_cell.sv =====
// ----------------------------------------------------------------------------
// trpn_cell: one stack slot
// Holds one typed element; takes the element above or below on a shift.
// ----------------------------------------------------------------------------
module trpn_cell (
  input  logic                 clk_i,
  input  trpn_pkg::cell_ctrl_t ctrl_i,
  input  logic                 is_top_i,
  input  trpn_pkg::elem_t      top_i,
  input  trpn_pkg::elem_t      from_up_i,
  input  trpn_pkg::elem_t      from_down_i,
  output trpn_pkg::elem_t      elem_o
);
  import trpn_pkg::*;

  elem_t elem_d, elem_q;

  always_comb begin
    elem_d = elem_q;
    if (is_top_i) begin
      if (ctrl_i.load_top) elem_d = top_i;
    end else begin
      case (ctrl_i.shift)
        SH_PUSH: elem_d = from_up_i;
        SH_POP:  elem_d = from_down_i;
        default: elem_d = elem_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign elem_o = elem_q;
endmodule

// ===== rtl/trpn_divider.sv =====
// ----------------------------------------------------------------------------
// trpn_divider: iterative signed divider
// Restoring divide on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module trpn_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        busy_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);
  import trpn_pkg::*;

  logic [5:0]  cnt_d, cnt_q;
  logic [31:0] q_d, q_q, r_d, r_q, b_d, b_q;
  logic        sq_d, sq_q, sr_d, sr_q;
  logic [32:0] trial;

  always_comb begin
    cnt_d = cnt_q;
    q_d   = q_q;
    r_d   = r_q;
    b_d   = b_q;
    sq_d  = sq_q;
    sr_d  = sr_q;
    trial = {r_q, q_q[31]} - {1'b0, b_q};
    if (start_i) begin
      cnt_d = 6'd32;
      q_d   = a_i[31] ? (32'd0 - a_i) : a_i;
      b_d   = b_i[31] ? (32'd0 - b_i) : b_i;
      r_d   = '0;
      sq_d  = a_i[31] ^ b_i[31];
      sr_d  = a_i[31];
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (!trial[32]) begin
        r_d = trial[31:0];
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = {r_q[30:0], q_q[31]};
        q_d = {q_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q  <= q_d;
    r_q  <= r_d;
    b_q  <= b_d;
    sq_q <= sq_d;
    sr_q <= sr_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quot_o = sq_q ? (32'd0 - q_q) : q_q;
  assign rem_o  = sr_q ? (32'd0 - r_q) : r_q;
endmodule

// ===== rtl/typed_stack_rpn_alu.sv =====
// ----------------------------------------------------------------------------
// typed_stack_rpn_alu: typed RPN operand stack with integer and boolean ALU
// Stack kept in a shifting chain of cells; the top cell is at index 0.
// ----------------------------------------------------------------------------
// From accept to result: clear, print and unused kinds go straight to done; push
// and dup go through push; not and drop pop one cell first; two-operand ops pop
// two; swap pushes both back; div and mod wait on the one-bit-per-cycle divider.
// Throughput: one item at a time; the next item is accepted the cycle after the
// result is registered, and a result that waits holds the next item at its end.
// Reset: depth, control and result valid clear at once; cells are left unset.
module typed_stack_rpn_alu #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  trpn_cmd_if.sink      cmd,
  trpn_res_if.source    res
);
  import trpn_pkg::*;

  localparam int CntW = $clog2(STACK_DEPTH + 1);

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  kind_e               kind_q;
  logic [DataW-1:0]    opv_q;
  elem_t               r_q, l_q, r_d, l_d;
  status_e             st_q, st_d;
  elem_t               push_q, push_d, push2_q, push2_d;
  cell_ctrl_t          ctrl;
  elem_t               top_in;
  elem_t               cells [STACK_DEPTH];
  logic                res_v_q;
  logic [StatusW-1:0]  res_st_q;
  logic                res_pv_q, res_pb_q;
  logic [DataW-1:0]    res_val_q;
  logic [DepthOW-1:0]  res_dep_q;
  logic                div_start, div_busy;
  logic [31:0]         quot, remd;
  logic                fin;
  logic                acc;
  logic                cmp_lt, cmp_gt;
  logic [31:0]         prod_q;

  assign acc       = cmd.valid && cmd.ready;
  assign cmd.ready = (state_q == S_IDLE);
  // The finished item moves into the result register once that register is free.
  assign fin       = (state_q == S_DONE) && (!res_v_q || res.ready);

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    trpn_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .is_top_i   (i == 0),
      .top_i      (top_in),
      .from_up_i  ((i == 0) ? cells[0] : cells[(i == 0) ? 0 : i-1]),
      .from_down_i((i == STACK_DEPTH-1) ? cells[i] : cells[(i == STACK_DEPTH-1) ? i : i+1]),
      .elem_o     (cells[i])
    );
  end

  trpn_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .a_i    (l_q.value),
    .b_i    (r_q.value),
    .busy_o (div_busy),
    .quot_o (quot),
    .rem_o  (remd)
  );

  assign cmp_lt = $signed(l_q.value) < $signed(r_q.value);
  assign cmp_gt = $signed(r_q.value) < $signed(l_q.value);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (acc) begin
        case (kind_e'(cmd.kind))
          K_PUSH_INT, K_PUSH_BOOL, K_DUP:       state_d = S_PUSH;
          K_NOT, K_DROP, K_SWAP, K_ADD, K_SUB, K_MUL, K_DIV, K_MOD,
          K_LT, K_GT, K_LE, K_GE, K_EQ:        state_d = S_POP_R;
          default:                              state_d = S_DONE;
        endcase
      end
      S_POP_R: begin
        if (cnt_q == '0 || kind_q == K_DROP || kind_q == K_NOT) state_d = S_PUSH;
        else state_d = S_POP_L;
      end
      S_POP_L: begin
        if (cnt_q != '0 && !r_q.tag && !cells[0].tag
            && (kind_q == K_DIV || kind_q == K_MOD) && r_q.value != '0)
          state_d = S_DIV;
        else if (kind_q == K_SWAP && cnt_q != '0) state_d = S_PUSH2;
        else state_d = S_PUSH;
      end
      S_DIV:   if (!div_busy && !div_start) state_d = S_PUSH;
      S_PUSH2: state_d = S_PUSH;
      S_PUSH:  state_d = S_DONE;
      S_DONE:  if (fin) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and cell control.
  always_comb begin
    cnt_d     = cnt_q;
    r_d       = r_q;
    l_d       = l_q;
    st_d      = st_q;
    push_d    = push_q;
    push2_d   = push2_q;
    ctrl      = '{shift: SH_HOLD, load_top: 1'b0};
    top_in    = cells[1];
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        st_d   = ST_OK;
        push_d = '{tag: 1'b1, value: '0};
        if (acc && cmd.kind == K_CLEAR) cnt_d = '0;
      end
      S_POP_R: begin
        if (cnt_q == '0) st_d = ST_EMPTY;
        else begin
          r_d           = cells[0];
          ctrl.shift    = SH_POP;
          ctrl.load_top = 1'b1;
          cnt_d         = cnt_q - CntW'(1);
          if (kind_q == K_NOT) begin
            if (!cells[0].tag) st_d = ST_TYPE;
            else push_d = '{tag: 1'b1, value: {31'd0, cells[0].value == '0}};
          end
        end
      end
      S_POP_L: begin
        if (st_q == ST_OK) begin
          if (cnt_q == '0) st_d = ST_EMPTY;
          else begin
            l_d           = cells[0];
            ctrl.shift    = SH_POP;
            ctrl.load_top = 1'b1;
            cnt_d         = cnt_q - CntW'(1);
            if (kind_q == K_SWAP) begin
              push2_d = r_q;
              push_d  = cells[0];
            end else if (kind_q == K_EQ) begin
              push_d = '{tag: 1'b1,
                         value: {31'd0, (r_q.tag == cells[0].tag)
                                        && (r_q.value == cells[0].value)}};
            end else if (r_q.tag || cells[0].tag) st_d = ST_TYPE;
            else if ((kind_q == K_DIV || kind_q == K_MOD) && r_q.value == '0)
              st_d = ST_DIV0;
            else if (kind_q == K_DIV || kind_q == K_MOD) div_start = 1'b0;
          end
        end
      end
      S_DIV: begin
        if (!div_busy && push_q.tag) begin
          div_start = 1'b1;
          push_d.tag = 1'b0;
        end else if (!div_busy) begin
          push_d = '{tag: 1'b0, value: (kind_q == K_DIV) ? quot : remd};
        end
      end
      S_PUSH2: begin
        top_in        = push2_q;
        ctrl.shift    = SH_PUSH;
        ctrl.load_top = 1'b1;
        cnt_d         = cnt_q + CntW'(1);
      end
      S_PUSH: begin
        if (st_q == ST_OK && kind_q != K_DROP) begin
          case (kind_q)
            K_PUSH_INT:  push_d = '{tag: 1'b0, value: opv_q};
            K_PUSH_BOOL: push_d = '{tag: 1'b1, value: {31'd0, opv_q[0]}};
            K_DUP:       push_d = cells[0];
            K_ADD:       push_d = '{tag: 1'b0, value: l_q.value + r_q.value};
            K_SUB:       push_d = '{tag: 1'b0, value: l_q.value - r_q.value};
            K_MUL:       push_d = '{tag: 1'b0, value: prod_q};
            K_LT:        push_d = '{tag: 1'b1, value: {31'd0, cmp_lt}};
            K_GT:        push_d = '{tag: 1'b1, value: {31'd0, cmp_gt}};
            K_LE:        push_d = '{tag: 1'b1, value: {31'd0, !cmp_gt}};
            K_GE:        push_d = '{tag: 1'b1, value: {31'd0, !cmp_lt}};
            default:     push_d = push_q;
          endcase
          if ((kind_q == K_DUP && cnt_q == '0)) st_d = ST_EMPTY;
          else if (cnt_q >= CntW'(STACK_DEPTH)) st_d = ST_FULL;
          else begin
            top_in        = push_d;
            ctrl.shift    = SH_PUSH;
            ctrl.load_top = 1'b1;
            cnt_d         = cnt_q + CntW'(1);
          end
        end
      end
      S_DONE: begin
        if (kind_q == K_PRINT && cnt_q == '0) st_d = ST_EMPTY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (fin) res_v_q <= 1'b1;
      else if (res.valid && res.ready) res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      kind_q <= kind_e'(cmd.kind);
      opv_q  <= cmd.operand_value;
    end
    r_q     <= r_d;
    l_q     <= l_d;
    st_q    <= st_d;
    push_q  <= push_d;
    push2_q <= push2_d;
    // The product is ready when the left operand has just been popped.
    prod_q  <= l_d.value * r_q.value;
    if (fin) begin
      res_st_q  <= st_d;
      res_pv_q  <= (kind_q == K_PRINT) && (cnt_q != '0);
      res_val_q <= ((kind_q == K_PRINT) && (cnt_q != '0)) ? cells[0].value : '0;
      res_pb_q  <= (kind_q == K_PRINT) && (cnt_q != '0) && cells[0].tag;
      res_dep_q <= DepthOW'(cnt_q);
    end
  end

  assign res.valid         = res_v_q;
  assign res.status        = res_st_q;
  assign res.print_valid   = res_pv_q;
  assign res.print_value   = res_val_q;
  assign res.print_is_bool = res_pb_q;
  assign res.stack_depth   = res_dep_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> !cmd.ready) else $error("second item taken while busy");
  a_print_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.print_valid |-> res.status == ST_OK)
    else $error("print shown with an error status");
endmodule
